// ===== rtl/aifp_pkg.sv =====
// Package for the acknowledgement interval frame pacer.
// Holds the sequencer state type, the item codes and the serial word size.
// Used by the top level, its checker and the testbench; depends on nothing else.
package aifp_pkg;

	localparam int unsigned TW = 64;
	localparam int unsigned BW = 6;

	localparam logic [1:0] FUNC_QUERY = 2'd0;
	localparam logic [1:0] FUNC_SENT  = 2'd1;
	localparam logic [1:0] FUNC_ACK   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QUERY,
		ST_ACK,
		ST_DIV,
		ST_DONE
	} aifp_state_t;

endpackage

// ===== rtl/ack_interval_frame_pacer_top.sv =====
// A query compares its time since the last sent event with the mean interval; a sent
// event or unused code goes straight to the result; the input reopens with the result.
// The 64-bit arithmetic runs one bit per cycle: a serial pass over the words for the
// compare or the interval and window sum, then for an ack a restoring sum/count divide.
// Reset (arst_n low, asynchronous) empties the window and clears all counters.
// Depends on aifp_pkg; the interval window is a local memory of WINDOW words.
module ack_interval_frame_pacer_top
	import aifp_pkg::*;
#(
	parameter int unsigned WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [63:0]        event_time,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               may_send,
	output logic signed [31:0] frames_in_flight
);

	localparam int unsigned CW = $clog2(WINDOW + 1);
	localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	aifp_state_t state_q, state_d;

	logic [TW-1:0] mem [WINDOW];
	logic [TW-1:0] mem_rd_q;

	logic [TW-1:0] t_q, la_q, ls_q, sum_q, avg_q, v_q, old_q;
	logic [BW-1:0] bit_q;
	logic [CW-1:0] count_q, rem_q;
	logic [AW-1:0] oldest_q;
	logic [31:0]   flight_q;
	logic          la_nz_q, tnz_q, b1_q, b2_q, cy_q, may_q;

	logic          accept, last, full, out_free;
	logic          tb, vb, nb1, ob, sb, ncy, rb, nb2, db, ab, qb;
	logic [CW:0]   remsh;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [TW-1:0] wr_data;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign last     = &bit_q;
	assign full     = (count_q == CW'(WINDOW));
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		tb    = t_q[0];
		vb    = tb ^ la_q[0] ^ b1_q;
		nb1   = (~tb & la_q[0]) | (~(tb ^ la_q[0]) & b1_q);
		ob    = full & old_q[0];
		sb    = sum_q[0] ^ vb ^ cy_q;
		ncy   = (sum_q[0] & vb) | (sum_q[0] & cy_q) | (vb & cy_q);
		rb    = sb ^ ob ^ b2_q;
		db    = tb ^ ls_q[0] ^ b1_q;
		ab    = avg_q[0];
		nb2   = 1'b0;
		remsh = {rem_q, sum_q[TW-1]};
		qb    = (count_q != '0) && (remsh >= {1'b0, count_q});
		unique case (state_q)
			ST_ACK:   nb2 = (~sb & ob) | (~(sb ^ ob) & b2_q);
			ST_QUERY: nb2 = (~db & ab) | (~(db ^ ab) & b2_q);
			default:  nb2 = 1'b0;
		endcase
		if (state_q == ST_QUERY) begin
			nb1 = (~tb & ls_q[0]) | (~(tb ^ ls_q[0]) & b1_q);
		end
	end

	assign wr_en   = (state_q == ST_ACK) && last && la_nz_q;
	assign wr_addr = full ? oldest_q : count_q[AW-1:0];
	assign wr_data = {vb, v_q[TW-1:1]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_q <= mem[oldest_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_QUERY) begin
						state_d = ST_QUERY;
					end else if (func == FUNC_ACK) begin
						state_d = ST_ACK;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_QUERY: if (last) state_d = ST_DONE;
			ST_ACK:   if (last) state_d = ST_DIV;
			ST_DIV:   if (last) state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q             <= '0;
			ls_q             <= '0;
			sum_q            <= '0;
			avg_q            <= '0;
			count_q          <= '0;
			oldest_q         <= '0;
			flight_q         <= '0;
			la_nz_q          <= 1'b0;
			out_valid        <= 1'b0;
			may_send         <= 1'b0;
			frames_in_flight <= '0;
			bit_q            <= '0;
			may_q            <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != ST_DONE) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bit_q <= '0;
						may_q <= 1'b0;
						if (func == FUNC_SENT) begin
							ls_q     <= event_time;
							flight_q <= flight_q + 32'd1;
						end
					end
				end
				ST_QUERY: begin
					ls_q  <= {ls_q[0], ls_q[TW-1:1]};
					avg_q <= {avg_q[0], avg_q[TW-1:1]};
					bit_q <= bit_q + 1'b1;
					if (last) begin
						may_q <= ~nb2;
					end
				end
				ST_ACK: begin
					if (la_nz_q) begin
						sum_q <= {rb, sum_q[TW-1:1]};
					end else begin
						sum_q <= {sum_q[0], sum_q[TW-1:1]};
					end
					bit_q <= bit_q + 1'b1;
					if (last) begin
						la_q     <= {tb, t_q[TW-1:1]};
						la_nz_q  <= tnz_q | tb;
						flight_q <= flight_q - 32'd1;
						if (la_nz_q) begin
							if (full) begin
								oldest_q <= (oldest_q == AW'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
							end else begin
								count_q <= count_q + 1'b1;
							end
						end
					end else begin
						la_q <= {la_q[0], la_q[TW-1:1]};
					end
				end
				ST_DIV: begin
					sum_q <= {sum_q[TW-2:0], sum_q[TW-1]};
					avg_q <= {avg_q[TW-2:0], qb};
					bit_q <= bit_q + 1'b1;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid        <= 1'b1;
						may_send         <= may_q;
						frames_in_flight <= flight_q;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				t_q   <= event_time;
				old_q <= mem_rd_q;
				b1_q  <= 1'b0;
				b2_q  <= 1'b0;
				cy_q  <= 1'b0;
				tnz_q <= 1'b0;
				rem_q <= '0;
			end
			ST_QUERY: begin
				t_q  <= {tb, t_q[TW-1:1]};
				b1_q <= nb1;
				b2_q <= nb2;
			end
			ST_ACK: begin
				t_q   <= {tb, t_q[TW-1:1]};
				v_q   <= {vb, v_q[TW-1:1]};
				old_q <= {old_q[0], old_q[TW-1:1]};
				b1_q  <= nb1;
				b2_q  <= nb2;
				cy_q  <= ncy;
				tnz_q <= tnz_q | tb;
			end
			ST_DIV: begin
				if (qb) begin
					rem_q <= CW'(remsh - {1'b0, count_q});
				end else begin
					rem_q <= remsh[CW-1:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/aifp_checker.sv =====
// Port-level checker for the acknowledgement interval frame pacer.
// Watches only the top-level ports; bound to ack_interval_frame_pacer_top below.
// Depends on aifp_pkg.
module aifp_checker
	import aifp_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         func,
	input logic [63:0]        event_time,
	input logic               out_valid,
	input logic               out_stall,
	input logic               may_send,
	input logic signed [31:0] frames_in_flight
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(may_send) && $stable(frames_in_flight))
		else $error("stalled result word changed");

	// one word in work at a time
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in work");

	// stay busy until the accepted word has produced its result
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_valid |=> in_stall || out_valid)
		else $error("input reopened without a result");

endmodule

bind ack_interval_frame_pacer_top aifp_checker u_aifp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.func             (func),
	.event_time       (event_time),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.may_send         (may_send),
	.frames_in_flight (frames_in_flight)
);

// ===== tb/sv/tb_top.sv =====
// Testbench for ack_interval_frame_pacer_top: directed and random words on a valid/stall
// channel, a scoreboard class that predicts each verdict and in-flight count.
// Depends on aifp_pkg and the top level of the pacer.
module tb_top;
	import aifp_pkg::*;

	localparam int unsigned PACE_WINDOW = 10;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned RANDOM_WORDS = 550;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 200;

	typedef struct packed {
		logic               may;
		logic signed [31:0] in_flight;
	} pace_verdict_t;

	class pacer_scoreboard;
		logic [63:0]        intervals [PACE_WINDOW];
		int unsigned        fill;
		int unsigned        head;
		logic [63:0]        prev_ack;
		logic [63:0]        prev_sent;
		logic signed [31:0] outstanding;
		pace_verdict_t      pending_verdicts [$];
		int unsigned        errors;

		function new();
			fill = 0;
			head = 0;
			prev_ack = '0;
			prev_sent = '0;
			outstanding = '0;
			errors = 0;
		endfunction

		function logic [63:0] mean_interval();
			logic [63:0] sum;
			sum = '0;
			for (int unsigned k = 0; k < fill; k++) begin
				sum = sum + intervals[k];
			end
			if (sum == 0 || fill == 0) begin
				return '0;
			end
			return sum / 64'(fill);
		endfunction

		function void record_interval(logic [63:0] gap);
			if (fill < PACE_WINDOW) begin
				intervals[(head + fill) % PACE_WINDOW] = gap;
				fill++;
			end else begin
				intervals[head] = gap;
				head = (head + 1) % PACE_WINDOW;
			end
		endfunction

		function void note_word(logic [1:0] f, logic [63:0] t);
			pace_verdict_t v;
			v.may = 1'b0;
			case (f)
				FUNC_QUERY: begin
					v.may = ((t - prev_sent) < mean_interval()) ? 1'b0 : 1'b1;
				end
				FUNC_SENT: begin
					prev_sent = t;
					outstanding = outstanding + 32'sd1;
				end
				FUNC_ACK: begin
					if (prev_ack != 0) begin
						record_interval(t - prev_ack);
					end
					prev_ack = t;
					outstanding = outstanding - 32'sd1;
				end
				default: begin
				end
			endcase
			v.in_flight = outstanding;
			pending_verdicts.insert(pending_verdicts.size(), v);
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_verdict(logic may, logic signed [31:0] in_flight);
			pace_verdict_t v;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("unexpected word may_send=%0b frames_in_flight=%0d",
					may, in_flight));
			end else begin
				v = pending_verdicts.pop_front();
				if (may !== v.may) begin
					report($sformatf("may_send got %0b want %0b", may, v.may));
				end
				if (in_flight !== v.in_flight) begin
					report($sformatf("frames_in_flight got %0d want %0d",
						in_flight, v.in_flight));
				end
			end
		endtask

		task flush_check();
			if (pending_verdicts.size() != 0) begin
				report($sformatf("%0d words never arrived", pending_verdicts.size()));
			end
		endtask

		function int unsigned pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         func;
	logic [63:0]        event_time;
	logic               out_valid;
	logic               out_stall;
	logic               may_send;
	logic signed [31:0] frames_in_flight;

	pacer_scoreboard verdicts;
	bit              idle_on;
	bit              hold_req;
	logic [63:0]     clock_ms;
	logic [63:0]     last_sent_ms;

	ack_interval_frame_pacer_top #(.WINDOW(PACE_WINDOW)) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.event_time       (event_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.may_send         (may_send),
		.frames_in_flight (frames_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic push_word(input logic [1:0] f, input logic [63:0] t);
		bit taken;
		in_valid <= 1'b1;
		func <= f;
		event_time <= t;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		verdicts.note_word(f, t);
	endtask

	task automatic offer(input logic [1:0] f, input logic [63:0] t);
		int unsigned g;
		push_word(f, t);
		if (f == FUNC_SENT) begin
			last_sent_ms = t;
		end
		g = idle_on ? pick_gap() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (verdicts.pending() != 0) @(posedge clk);
	endtask

	initial begin : receiver
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(negedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				verdicts.check_verdict(may_send, frames_in_flight);
			end
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (stall_left == 0 && idle_on) begin
					stall_left = pick_gap();
				end
				out_stall <= (stall_left > 0);
				if (stall_left > 0) begin
					stall_left--;
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned r;
		logic [1:0]  f;
		logic [63:0] t;
		verdicts = new();
		idle_on = 1'b1;
		hold_req = 1'b0;
		last_sent_ms = '0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_QUERY;
		event_time <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		offer(FUNC_QUERY, 64'd0);
		offer(FUNC_SENT, 64'd100);
		offer(FUNC_QUERY, 64'd50);
		offer(FUNC_ACK, 64'd0);
		offer(FUNC_ACK, 64'd40);
		offer(FUNC_ACK, 64'd70);
		offer(FUNC_QUERY, 64'd129);
		offer(FUNC_QUERY, 64'd130);
		offer(FUNC_ACK, 64'd20);
		offer(FUNC_QUERY, 64'd130);
		offer(FUNC_ACK, 64'd20);
		offer(FUNC_SENT, 64'hFFFF_FFFF_FFFF_FFFF);
		offer(FUNC_QUERY, 64'd0);
		offer(FUNC_ACK, 64'd40);
		offer(FUNC_QUERY, 64'd0);
		offer(FUNC_ACK, 64'd0);
		offer(FUNC_ACK, 64'd5);
		offer(FUNC_ACK, 64'd45);
		offer(FUNC_SENT, 64'd50);
		offer(FUNC_QUERY, 64'd89);
		offer(FUNC_QUERY, 64'd90);
		offer(FUNC_UNUSED, 64'd0);

		clock_ms = {$urandom, $urandom};
		for (int unsigned i = 0; i < RANDOM_WORDS; i++) begin
			if (i % 50 == 0) begin
				idle_on = ($urandom_range(0, 3) != 0);
			end
			if (i == 200) begin
				hold_req = 1'b1;
			end
			if (i == 350) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			if (i % 150 == 75) begin
				clock_ms = {$urandom, $urandom};
			end
			r = $urandom_range(0, 99);
			if (r < 35) begin
				clock_ms = clock_ms + 64'($urandom_range(20, 60));
				offer(FUNC_ACK, clock_ms);
			end else if (r < 57) begin
				clock_ms = clock_ms + 64'($urandom_range(0, 10));
				offer(FUNC_SENT, clock_ms);
			end else if (r < 88) begin
				offer(FUNC_QUERY, last_sent_ms + 64'($urandom_range(0, 90)));
			end else begin
				f = 2'($urandom_range(0, 3));
				t = ($urandom_range(0, 9) == 0) ? 64'd0 : {$urandom, $urandom};
				offer(f, t);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		verdicts.flush_check();
		if (verdicts.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== ack_interval_frame_pacer_top.f =====
rtl/aifp_pkg.sv
rtl/ack_interval_frame_pacer_top.sv
rtl/aifp_checker.sv
tb/sv/tb_top.sv
